/* design/cbe_pkg.sv */
// Shared types, constants and tables for the class bound entropy block.
package cbe_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEEP = 2'd2;

    localparam logic [15:0] STEEP_RESET = 16'd2564;

    // Field widths
    localparam int FIELD_W   = 32;
    localparam int THETA_W   = 24;
    localparam int SUM_W     = 32;
    localparam int ULOG_W    = 40;
    localparam int LOG_W     = 21;
    localparam int ENT_W     = 20;
    localparam int TOTAL_W   = 30;
    localparam int CLSOUT_W  = 10;
    localparam int REM_W     = 42;
    localparam int LOW_W     = 24;
    localparam int EXP_W     = 63;
    localparam int ACC_W     = 126;

    // log2 of 2^23 in Q.16
    localparam logic [LOG_W-1:0] LOG_BIAS = 21'(23 * 65536);
    localparam logic [ENT_W-1:0] ENT_MAX  = '1;

    typedef logic [31:0][EXP_W-1:0] f_tab_t;

    // Repeated squares of exp(-2^-24) in Q2.62, one per exponent bit
    function automatic f_tab_t exp_factors();
        f_tab_t            tab;
        logic [EXP_W-1:0]  f;
        logic [ACC_W-1:0]  p;
        f = 63'h3FFF_FFC0_0000_2000;
        for (int k = 0; k < 32; k++)
        begin
            tab[k] = f;
            p = {63'b0, f} * {63'b0, f} + (126'(1) << 61);
            f = p[124:62];
        end
        return tab;
    endfunction

    typedef enum logic [4:0] {
        ST_IDLE, ST_DA_LD, ST_DA_STEP, ST_XMUL, ST_EXP_BIT, ST_EXP_PP, ST_EXP_RND,
        ST_DB_LD, ST_DB_STEP, ST_TH_ST, ST_TL_LD, ST_TL_NORM, ST_TL_SQ, ST_TERM,
        ST_CHK, ST_SL_LD, ST_SL_NORM, ST_SL_SQ, ST_DH_LD, ST_DH_STEP, ST_H_CALC,
        ST_H_ZERO, ST_FIN
    } cbe_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_DA_LD, OP_DIV_STEP, OP_XMUL, OP_EXP_PP, OP_EXP_RND,
        OP_DB_LD, OP_TH_ST, OP_TL_LD, OP_SL_LD, OP_NORM, OP_SQ, OP_TERM, OP_DH_LD,
        OP_H_CALC, OP_H_ZERO, OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [5:0]  idx;
        logic [1:0]  sub;
    } dp_cmd_t;

    typedef struct packed {
        logic empty_range;
        logic x_bit;
        logic norm_done;
        logic theta_zero;
        logic sum_zero;
        logic last_item;
        logic out_free;
    } dp_stat_t;

endpackage

/* design/cbe_in_if.sv */
// Input channel: one bound word per item.
interface cbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] item_bound;
    logic               last_in_class;
    logic               last_class;

    modport source (output valid, item_bound, last_in_class, last_class, input ready);
    modport sink   (input valid, item_bound, last_in_class, last_class, output ready);
endinterface

/* design/cbe_out_if.sv */
// Output channel: one entropy word per finished class.
interface cbe_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] class_entropy_value;
    logic [29:0] difficulty_total;
    logic [9:0]  class_number;
    logic        final_class;

    modport source (output valid, class_entropy_value, difficulty_total, class_number,
                    final_class, input ready);
    modport sink   (input valid, class_entropy_value, difficulty_total, class_number,
                    final_class, output ready);
endinterface

/* design/class_bound_entropy.sv */
// Top level of the class bound entropy block.
// Each bound word is worked through one at a time. A 17-step division gives the normalised
// distance; it is skipped for an empty interval. The exponential takes one step per bit of
// the 32-bit exponent; a set bit adds four passes through the single shared 32x32 multiplier
// and a rounding step. A 24-step division then gives theta. For a non-zero theta, a log2
// follows, with normalising shifts and 16 squarings. The time an item takes is mostly set by
// the number of set exponent bits. The last item of a class adds log2 of the sum and the final
// division, or only a zero result when the sum is zero. A finished result waits in the output
// register. The input is held while an item is in progress, which includes a class that closes
// while the previous result is still waiting.
module class_bound_entropy
    import cbe_pkg::*;
#(
    parameter int MAX_CLASSES = 1024,
    parameter int BOUND_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cbe_in_if.sink               in_ch,
    cbe_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    cbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    cbe_dpath #(
        .MAX_CLASSES (MAX_CLASSES),
        .BOUND_WIDTH (BOUND_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_bound    (in_ch.item_bound),
        .last_in_class (in_ch.last_in_class),
        .last_class    (in_ch.last_class),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_entropy   (out_ch.class_entropy_value),
        .out_total     (out_ch.difficulty_total),
        .out_class     (out_ch.class_number),
        .out_final     (out_ch.final_class)
    );

    // Busy after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken while an item is in progress");

    // A result is only written into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FIN |-> (!out_ch.valid || out_ch.ready))
        else $error("result overwrote a pending word");

    // A taken result leaves unless a new one lands
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && cmd.op != OP_FIN |=> !out_ch.valid)
        else $error("result repeated after hand-off");

endmodule

/* design/cbe_ctrl.sv */
// Sequencer for the entropy datapath: divider, exponential and log steps.
module cbe_ctrl
    import cbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    cbe_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] sub_reg, sub_next;

    // Hold state and step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
        end
    end

    // Advance through the per-item sequence
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_DA_LD;
            ST_DA_LD:
            begin
                cnt_next   = '0;
                state_next = stat.empty_range ? ST_XMUL : ST_DA_STEP;
            end
            ST_DA_STEP:
            begin
                if (cnt_reg == 6'd16) state_next = ST_XMUL;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_XMUL:
            begin
                cnt_next   = '0;
                state_next = ST_EXP_BIT;
            end
            ST_EXP_BIT:
            begin
                if (stat.x_bit)
                begin
                    sub_next   = '0;
                    state_next = ST_EXP_PP;
                end
                else if (cnt_reg == 6'd31) state_next = ST_DB_LD;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_EXP_PP:
            begin
                if (sub_reg == 2'd3) state_next = ST_EXP_RND;
                else sub_next = sub_reg + 2'd1;
            end
            ST_EXP_RND:
            begin
                if (cnt_reg == 6'd31) state_next = ST_DB_LD;
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = ST_EXP_BIT;
                end
            end
            ST_DB_LD:
            begin
                cnt_next   = '0;
                state_next = ST_DB_STEP;
            end
            ST_DB_STEP:
            begin
                if (cnt_reg == 6'd23) state_next = ST_TH_ST;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_TH_ST:   state_next = stat.theta_zero ? ST_CHK : ST_TL_LD;
            ST_TL_LD:   state_next = ST_TL_NORM;
            ST_TL_NORM:
            begin
                if (stat.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_TL_SQ;
                end
            end
            ST_TL_SQ:
            begin
                if (cnt_reg == 6'd15) state_next = ST_TERM;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_TERM:    state_next = ST_CHK;
            ST_CHK:
            begin
                if (!stat.last_item) state_next = ST_IDLE;
                else if (stat.sum_zero) state_next = ST_H_ZERO;
                else state_next = ST_SL_LD;
            end
            ST_SL_LD:   state_next = ST_SL_NORM;
            ST_SL_NORM:
            begin
                if (stat.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_SL_SQ;
                end
            end
            ST_SL_SQ:
            begin
                if (cnt_reg == 6'd15) state_next = ST_DH_LD;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_DH_LD:
            begin
                cnt_next   = '0;
                state_next = ST_DH_STEP;
            end
            ST_DH_STEP:
            begin
                if (cnt_reg == 6'd23) state_next = ST_H_CALC;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_H_CALC:  state_next = ST_FIN;
            ST_H_ZERO:  state_next = ST_FIN;
            ST_FIN:     if (stat.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.idx  = cnt_reg;
        cmd.sub  = sub_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_ACCEPT;
            end
            ST_DA_LD:   cmd.op = OP_DA_LD;
            ST_DA_STEP: cmd.op = OP_DIV_STEP;
            ST_XMUL:    cmd.op = OP_XMUL;
            ST_EXP_PP:  cmd.op = OP_EXP_PP;
            ST_EXP_RND: cmd.op = OP_EXP_RND;
            ST_DB_LD:   cmd.op = OP_DB_LD;
            ST_DB_STEP: cmd.op = OP_DIV_STEP;
            ST_TH_ST:   cmd.op = OP_TH_ST;
            ST_TL_LD:   cmd.op = OP_TL_LD;
            ST_TL_NORM: cmd.op = OP_NORM;
            ST_TL_SQ:   cmd.op = OP_SQ;
            ST_TERM:    cmd.op = OP_TERM;
            ST_SL_LD:   cmd.op = OP_SL_LD;
            ST_SL_NORM: cmd.op = OP_NORM;
            ST_SL_SQ:   cmd.op = OP_SQ;
            ST_DH_LD:   cmd.op = OP_DH_LD;
            ST_DH_STEP: cmd.op = OP_DIV_STEP;
            ST_H_CALC:  cmd.op = OP_H_CALC;
            ST_H_ZERO:  cmd.op = OP_H_ZERO;
            ST_FIN:     if (stat.out_free) cmd.op = OP_FIN;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

/* design/cbe_dpath.sv */
// Datapath: config registers, shared divider, shared multiplier, sums and result register.
module cbe_dpath
    import cbe_pkg::*;
#(
    parameter int MAX_CLASSES = 1024,
    parameter int BOUND_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic [FIELD_W-1:0]   item_bound,
    input  logic                 last_in_class,
    input  logic                 last_class,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [ENT_W-1:0]     out_entropy,
    output logic [TOTAL_W-1:0]   out_total,
    output logic [CLSOUT_W-1:0]  out_class,
    output logic                 out_final
);

    localparam int BW_EFF = (BOUND_WIDTH > FIELD_W) ? FIELD_W : BOUND_WIDTH;
    localparam int SH     = FIELD_W - BW_EFF;
    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam f_tab_t F_TAB = exp_factors();

    // Sign-extend a bound from the active bound width
    function automatic logic signed [FIELD_W-1:0] sext_b(input logic [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = $signed(v << SH);
        return t >>> SH;
    endfunction

    logic [FIELD_W-1:0]  upper_reg, lower_reg, bound_reg;
    logic [15:0]         steep_reg;
    logic                last_item_reg, last_cls_reg;
    logic [REM_W-1:0]    rem_reg, den_reg;
    logic [LOW_W-1:0]    low_reg, q_reg;
    logic [31:0]         x_reg;
    logic [EXP_W-1:0]    r_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [THETA_W-1:0]  theta_reg;
    logic [31:0]         m_reg;
    logic [4:0]          n_reg;
    logic [15:0]         frac_reg;
    logic                hsat_reg;
    logic [ENT_W-1:0]    h_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [ULOG_W-1:0]   ulog_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                out_valid_reg;
    logic [ENT_W-1:0]    out_ent_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [CLSOUT_W-1:0] out_cls_reg;
    logic                out_final_reg;

    logic signed [FIELD_W-1:0] ub, lb, bb, bc;
    logic [FIELD_W:0]    span, diff;
    logic                empty;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod;
    logic [EXP_W-1:0]    f_sel;
    logic [ACC_W-1:0]    pp_sh, acc_sum, rnd;
    logic [REM_W:0]      div_t, div_d;
    logic                div_ge;
    logic [40:0]         r40;
    logic [REM_W-1:0]    den_b;
    logic [63:0]         num_b;
    logic [32:0]         sq;
    logic [LOG_W-1:0]    log_v, log_d;
    logic [28:0]         term;
    logic [ULOG_W:0]     ulog_add;
    logic [SUM_W:0]      sum_add;
    logic signed [26:0]  h_raw;
    logic [TOTAL_W:0]    total_add;
    logic [TOTAL_W-1:0]  total_sat;
    logic                out_take;

    // Clamp the bound and form the interval widths
    assign ub    = sext_b(upper_reg);
    assign lb    = sext_b(lower_reg);
    assign bb    = sext_b(bound_reg);
    assign empty = !(ub > lb);
    assign bc    = (bb < lb) ? lb : ((bb > ub) ? ub : bb);
    assign span  = {ub[FIELD_W-1], ub} - {lb[FIELD_W-1], lb};
    assign diff  = {ub[FIELD_W-1], ub} - {bc[FIELD_W-1], bc};

    // Share one 32x32 multiplier
    assign f_sel = F_TAB[cmd.idx[4:0]];
    assign log_v = {n_reg, frac_reg};
    assign log_d = LOG_BIAS - log_v;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_XMUL:
            begin
                mul_a = {16'b0, steep_reg};
                mul_b = {15'b0, q_reg[16:0]};
            end
            OP_EXP_PP:
            begin
                mul_a = cmd.sub[1] ? {1'b0, r_reg[62:32]} : r_reg[31:0];
                mul_b = cmd.sub[0] ? {1'b0, f_sel[62:32]} : f_sel[31:0];
            end
            OP_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            OP_TERM:
            begin
                mul_a = {8'b0, theta_reg};
                mul_b = {11'b0, log_d};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = {32'b0, mul_a} * {32'b0, mul_b};

    // Place partial products for the Q2.62 exponential product
    always_comb
    begin
        case (cmd.sub)
            2'd0:    pp_sh = {62'b0, prod};
            2'd3:    pp_sh = {prod, 62'b0} >> 0;
            default: pp_sh = {30'b0, prod, 32'b0};
        endcase
    end
    assign acc_sum = ((cmd.sub == 2'd0) ? '0 : acc_reg)
                     + ((cmd.sub == 2'd3) ? {prod[61:0], 64'b0} : pp_sh);
    assign rnd     = acc_reg + (126'(1) << 61);

    // Restoring divider step
    assign div_t  = {rem_reg, low_reg[LOW_W-1]};
    assign div_d  = div_t - {1'b0, den_reg};
    assign div_ge = div_t >= {1'b0, den_reg};

    // Operands for the theta division
    assign r40   = r_reg[62:22];
    assign den_b = (42'(1) << 41) - {1'b0, r40};
    assign num_b = {r40, 23'b0} + 64'(den_b >> 1);

    // Log squaring and per-item term
    assign sq       = prod[63:31];
    assign term     = 29'((64'(prod) + 64'd32768) >> 16);
    assign ulog_add = {1'b0, ulog_reg} + 41'(term);
    assign sum_add  = {1'b0, sum_reg} + 33'(q_reg);
    assign h_raw    = $signed(27'(log_v)) + $signed(27'(q_reg)) - $signed(27'(LOG_BIAS));

    // Saturate the running difficulty total
    assign total_add = {1'b0, total_reg} + 31'(h_reg);
    assign total_sat = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];

    assign out_take = out_valid_reg && out_ready;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            lower_reg <= '0;
            steep_reg <= STEEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UPPER: upper_reg <= cfg_data;
                CFG_LOWER: lower_reg <= cfg_data;
                CFG_STEEP: steep_reg <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Hold class sums, counters and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            ulog_reg      <= '0;
            cls_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_TH_ST)
                sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (cmd.op == OP_TERM)
                ulog_reg <= ulog_add[ULOG_W] ? '1 : ulog_add[ULOG_W-1:0];
            if (cmd.op == OP_FIN)
            begin
                sum_reg  <= '0;
                ulog_reg <= '0;
                if (last_cls_reg)
                begin
                    cls_reg   <= '0;
                    total_reg <= '0;
                end
                else
                begin
                    cls_reg   <= (cls_reg == CLS_W'(MAX_CLASSES - 1)) ? '0 : cls_reg + 1'b1;
                    total_reg <= total_sat;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Work registers of the datapath
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                bound_reg     <= item_bound;
                last_item_reg <= last_in_class;
                last_cls_reg  <= last_class;
            end
            OP_DA_LD:
            begin
                den_reg <= REM_W'(span[FIELD_W-1:0]);
                rem_reg <= REM_W'(diff[FIELD_W:1]);
                low_reg <= {diff[0], 23'b0};
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? div_d[REM_W-1:0] : div_t[REM_W-1:0];
                q_reg   <= {q_reg[LOW_W-2:0], div_ge};
                low_reg <= {low_reg[LOW_W-2:0], 1'b0};
            end
            OP_XMUL:
            begin
                x_reg <= prod[31:0];
                r_reg <= EXP_W'(1) << 62;
            end
            OP_EXP_PP:  acc_reg <= acc_sum;
            OP_EXP_RND: r_reg <= rnd[124:62];
            OP_DB_LD:
            begin
                den_reg <= den_b;
                rem_reg <= REM_W'(num_b[63:24]);
                low_reg <= num_b[23:0];
                q_reg   <= '0;
            end
            OP_TH_ST:   theta_reg <= q_reg;
            OP_TL_LD:
            begin
                m_reg    <= {8'b0, theta_reg};
                n_reg    <= 5'd31;
                frac_reg <= '0;
            end
            OP_SL_LD:
            begin
                m_reg    <= sum_reg;
                n_reg    <= 5'd31;
                frac_reg <= '0;
            end
            OP_NORM:
            begin
                if (!m_reg[31])
                begin
                    m_reg <= {m_reg[30:0], 1'b0};
                    n_reg <= n_reg - 5'd1;
                end
            end
            OP_SQ:
            begin
                m_reg    <= sq[32] ? sq[32:1] : sq[31:0];
                frac_reg <= {frac_reg[14:0], sq[32]};
            end
            OP_DH_LD:
            begin
                den_reg  <= REM_W'(sum_reg);
                rem_reg  <= REM_W'(ulog_reg[39:8]);
                low_reg  <= {ulog_reg[7:0], 16'b0};
                q_reg    <= '0;
                hsat_reg <= ulog_reg[39:8] >= sum_reg;
            end
            OP_H_CALC:
            begin
                if (hsat_reg || h_raw > $signed(27'(ENT_MAX))) h_reg <= ENT_MAX;
                else if (h_raw < 0) h_reg <= '0;
                else h_reg <= h_raw[ENT_W-1:0];
            end
            OP_H_ZERO:  h_reg <= '0;
            OP_FIN:
            begin
                out_ent_reg   <= h_reg;
                out_total_reg <= total_sat;
                out_cls_reg   <= CLSOUT_W'(cls_reg);
                out_final_reg <= last_cls_reg;
            end
            default: ;
        endcase
    end

    // Status back to the sequencer
    assign stat.empty_range = empty;
    assign stat.x_bit       = x_reg[cmd.idx[4:0]];
    assign stat.norm_done   = m_reg[31];
    assign stat.theta_zero  = (q_reg == '0);
    assign stat.sum_zero    = (sum_reg == '0);
    assign stat.last_item   = last_item_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_entropy = out_ent_reg;
    assign out_total   = out_total_reg;
    assign out_class   = out_cls_reg;
    assign out_final   = out_final_reg;

endmodule
